@@ rtl/dab_pkg.sv @@
// shared types and constants of the density advection block
`timescale 1ns / 1ps

package dab_pkg;

  localparam int GRID_LOG2    = 6;
  localparam int FRAC_BITS    = 28;
  localparam int POS_W        = GRID_LOG2 + FRAC_BITS;
  localparam int W_BITS       = 16;
  localparam int DENS_W       = 16;
  localparam int VEL_W        = 16;
  localparam int TS_W         = 16;
  localparam int PROD_W       = TS_W + VEL_W;
  localparam int BLEND_W      = DENS_W + W_BITS;
  localparam int ACC_W        = BLEND_W + W_BITS + 2;
  localparam int RND_SHIFT    = BLEND_W + W_BITS - DENS_W - 1;
  localparam int NUM_BANKS    = 4;
  localparam int BANK_AW      = 2 * GRID_LOG2 - 2;
  localparam int BANK_DEPTH   = 1 << BANK_AW;
  localparam int FIFO_LOG2    = 3;
  localparam int FIFO_DEPTH   = 1 << FIFO_LOG2;
  localparam int FIFO_CNT_W   = FIFO_LOG2 + 1;

  localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd6554;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ADVECT = 1'b1;

  typedef logic [DENS_W-1:0]    dens_t;
  typedef logic [W_BITS-1:0]    weight_t;
  typedef logic [GRID_LOG2-1:0] cell_idx_t;
  typedef logic [BANK_AW-1:0]   bank_addr_t;
  typedef logic [1:0]           bank_sel_t;

  typedef struct packed {
    dens_t blue;
    dens_t green;
    dens_t red;
  } rgb_t;

  typedef struct packed {
    logic                            wr_en;
    bank_sel_t                       wr_bank;
    bank_addr_t                      wr_addr;
    rgb_t                            wr_data;
    bank_addr_t [NUM_BANKS-1:0]      rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    cell_idx_t cx;
    cell_idx_t cy;
    logic      x0_odd;
    logic      y0_odd;
    weight_t   wx;
    weight_t   wy;
  } trace_t;

  typedef struct packed {
    rgb_t      rgb;
    cell_idx_t y;
    cell_idx_t x;
  } result_t;

endpackage

@@ rtl/dab_grid_mem.sv @@
// four-bank density grid memory split by cell parity
`timescale 1ns / 1ps

module dab_grid_mem import dab_pkg::*; (
  input  logic     clk,
  input  mem_req_t mem_req,
  output rgb_t     rd_data [NUM_BANKS]
);

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    rgb_t bank_mem [BANK_DEPTH];
    rgb_t rd_q_r;

    always_ff @(posedge clk) begin
      if (mem_req.wr_en && (mem_req.wr_bank == bank_sel_t'(g))) begin
        bank_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_q_r <= bank_mem[mem_req.rd_addr[g]];
    end

    assign rd_data[g] = rd_q_r;
  end

endmodule

@@ rtl/dab_backtrace.sv @@
// back-trace of the cell position and grid memory request generation
`timescale 1ns / 1ps

module dab_backtrace import dab_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_fire,
  input  logic                    in_mode,
  input  cell_idx_t               in_cx,
  input  cell_idx_t               in_cy,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  rgb_t                    in_rgb,
  input  logic [TS_W-1:0]         time_step,
  output mem_req_t                mem_req,
  output trace_t                  trace,
  output logic                    adv_pending
);

  logic                     s1_valid_r;
  logic                     s1_mode_r;
  cell_idx_t                s1_cx_r;
  cell_idx_t                s1_cy_r;
  rgb_t                     s1_rgb_r;
  logic [PROD_W-1:0]        s1_prod_x_r;
  logic [PROD_W-1:0]        s1_prod_y_r;
  logic signed [PROD_W:0]   prod_x;
  logic signed [PROD_W:0]   prod_y;
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  cell_idx_t                x0;
  cell_idx_t                x1;
  cell_idx_t                y0;
  cell_idx_t                y1;
  trace_t                   trace_r;

  assign prod_x = $signed({1'b0, time_step}) * in_vel_x;
  assign prod_y = $signed({1'b0, time_step}) * in_vel_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r   <= in_mode;
    s1_cx_r     <= in_cx;
    s1_cy_r     <= in_cy;
    s1_rgb_r    <= in_rgb;
    s1_prod_x_r <= prod_x[PROD_W-1:0];
    s1_prod_y_r <= prod_y[PROD_W-1:0];
  end

  // position mod grid, whole part on top, fraction below
  assign pos_x = {s1_cx_r, {FRAC_BITS{1'b0}}}
               - {s1_prod_x_r[POS_W-GRID_LOG2-1:0], {GRID_LOG2{1'b0}}};
  assign pos_y = {s1_cy_r, {FRAC_BITS{1'b0}}}
               - {s1_prod_y_r[POS_W-GRID_LOG2-1:0], {GRID_LOG2{1'b0}}};
  assign x0 = pos_x[POS_W-1:FRAC_BITS];
  assign y0 = pos_y[POS_W-1:FRAC_BITS];
  assign x1 = x0 + cell_idx_t'(1);
  assign y1 = y0 + cell_idx_t'(1);

  always_comb begin
    bank_sel_t sel;
    cell_idx_t xs;
    cell_idx_t ys;
    mem_req.wr_en   = s1_valid_r && (s1_mode_r == MODE_LOAD);
    mem_req.wr_bank = {s1_cy_r[0], s1_cx_r[0]};
    mem_req.wr_addr = {s1_cy_r[GRID_LOG2-1:1], s1_cx_r[GRID_LOG2-1:1]};
    mem_req.wr_data = s1_rgb_r;
    for (int b = 0; b < NUM_BANKS; b++) begin
      sel = bank_sel_t'(b);
      xs  = (x0[0] == sel[0]) ? x0 : x1;
      ys  = (y0[0] == sel[1]) ? y0 : y1;
      mem_req.rd_addr[b] = {ys[GRID_LOG2-1:1], xs[GRID_LOG2-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_r.valid <= 1'b0;
    end else begin
      trace_r.valid <= adv_pending;
    end
    trace_r.cx     <= s1_cx_r;
    trace_r.cy     <= s1_cy_r;
    trace_r.x0_odd <= x0[0];
    trace_r.y0_odd <= y0[0];
    trace_r.wx     <= pos_x[FRAC_BITS-1:FRAC_BITS-W_BITS];
    trace_r.wy     <= pos_y[FRAC_BITS-1:FRAC_BITS-W_BITS];
  end

  assign adv_pending = s1_valid_r && (s1_mode_r == MODE_ADVECT);
  assign trace       = trace_r;

endmodule

@@ rtl/dab_blend.sv @@
// two-stage bilinear blend of the four neighbor densities
`timescale 1ns / 1ps

module dab_blend import dab_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  trace_t  trace,
  input  rgb_t    rd_data [NUM_BANKS],
  output logic    s3_valid,
  output logic    res_valid,
  output result_t res
);

  typedef struct packed {
    logic [BLEND_W-1:0] blue;
    logic [BLEND_W-1:0] green;
    logic [BLEND_W-1:0] red;
  } col_t;

  function automatic logic [BLEND_W-1:0] lerp_y(dens_t a0, dens_t a1, weight_t w);
    logic signed [DENS_W:0]    diff;
    logic signed [BLEND_W+1:0] acc;
    diff = $signed({1'b0, a1}) - $signed({1'b0, a0});
    acc  = $signed({2'b00, a0, {W_BITS{1'b0}}}) + diff * $signed({1'b0, w});
    return acc[BLEND_W-1:0];
  endfunction

  function automatic dens_t lerp_x(logic [BLEND_W-1:0] c0, logic [BLEND_W-1:0] c1,
                                   weight_t w);
    logic signed [BLEND_W:0] diff;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] acc;
    rnd = '0;
    rnd[RND_SHIFT] = 1'b1;
    diff = $signed({1'b0, c1}) - $signed({1'b0, c0});
    acc  = $signed({2'b00, c0, {W_BITS{1'b0}}}) + diff * $signed({1'b0, w}) + rnd;
    return acc[BLEND_W+W_BITS-1 -: DENS_W];
  endfunction

  rgb_t      a00;
  rgb_t      a01;
  rgb_t      a10;
  rgb_t      a11;
  logic      s3_valid_r;
  cell_idx_t s3_x_r;
  cell_idx_t s3_y_r;
  weight_t   s3_wx_r;
  col_t      s3_c0_r;
  col_t      s3_c1_r;
  logic      res_valid_r;
  result_t   res_r;

  // neighbor a_xy sits in bank {y parity, x parity}
  assign a00 = rd_data[{trace.y0_odd, trace.x0_odd}];
  assign a01 = rd_data[{~trace.y0_odd, trace.x0_odd}];
  assign a10 = rd_data[{trace.y0_odd, ~trace.x0_odd}];
  assign a11 = rd_data[{~trace.y0_odd, ~trace.x0_odd}];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= trace.valid;
      res_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_x_r        <= trace.cx;
    s3_y_r        <= trace.cy;
    s3_wx_r       <= trace.wx;
    s3_c0_r.red   <= lerp_y(a00.red,   a01.red,   trace.wy);
    s3_c0_r.green <= lerp_y(a00.green, a01.green, trace.wy);
    s3_c0_r.blue  <= lerp_y(a00.blue,  a01.blue,  trace.wy);
    s3_c1_r.red   <= lerp_y(a10.red,   a11.red,   trace.wy);
    s3_c1_r.green <= lerp_y(a10.green, a11.green, trace.wy);
    s3_c1_r.blue  <= lerp_y(a10.blue,  a11.blue,  trace.wy);
  end

  always_ff @(posedge clk) begin
    res_r.x         <= s3_x_r;
    res_r.y         <= s3_y_r;
    res_r.rgb.red   <= lerp_x(s3_c0_r.red,   s3_c1_r.red,   s3_wx_r);
    res_r.rgb.green <= lerp_x(s3_c0_r.green, s3_c1_r.green, s3_wx_r);
    res_r.rgb.blue  <= lerp_x(s3_c0_r.blue,  s3_c1_r.blue,  s3_wx_r);
  end

  assign s3_valid  = s3_valid_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_res_follows_trace: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> $past(trace.valid, 2))
    else $error("blend result without a traced item two cycles earlier");

endmodule

@@ rtl/dab_out_fifo.sv @@
// result queue in front of the output channel
`timescale 1ns / 1ps

module dab_out_fifo import dab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  result_t               wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               rd_data,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_LOG2-1:0]   wr_ptr_r;
  logic [FIFO_LOG2-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  count_r;
  logic [FIFO_CNT_W-1:0]  count_nxt;
  logic                   pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign rd_data   = fifo_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    priority if (wr_en && !pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (pop && !wr_en) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + FIFO_LOG2'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_LOG2'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
    else $error("result queue written while full");

endmodule

@@ rtl/density_advection_bilinear.sv @@
// top level of the bilinear semi-Lagrangian density advection block
//
// in channel: tuser is the mode, load (store a cell's red, green, blue
// densities) or advect (back-trace a cell by time_step * velocity * grid size
// and blend the four wrapped neighbors). a load gives no result, an advect
// gives one result on the out channel, in order.
// cfg channel: one write of time_step, always ready; write it while idle.
// an advect result is registered in the back-trace, trace and blend stages.
// throughput: one item per cycle, loads and advects freely mixed; the grid
// sits in four parity banks so all four neighbors are read in the same cycle,
// and a load writes in the same pipeline stage where an advect reads.
// the out side is buffered by an 8-entry queue; in_tready drops only when
// queued plus in-flight results would fill it, so a stalled receiver backs
// up the in channel after a few cycles and nothing is lost.
// reset: pipeline and queue empty, time_step back to 6554; grid contents
// are undefined until loaded and need no clearing pass.
`timescale 1ns / 1ps

module density_advection_bilinear import dab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_x, cell_y, vel_x, vel_y, red_in, green_in, blue_in, zero pad
  input  logic [95:0] in_tdata,
  // mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_x, out_y, red_out, green_out, blue_out, zero pad
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [TS_W-1:0]       time_step_r;
  logic                  in_fire;
  rgb_t                  in_rgb;
  mem_req_t              mem_req;
  trace_t                trace;
  logic                  adv_pending;
  rgb_t                  rd_data [NUM_BANKS];
  logic                  s3_valid;
  logic                  res_valid;
  result_t               res;
  result_t               out_res;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      time_step_r <= cfg_data;
    end
  end

  // queued results plus advects still in the pipeline
  assign occupancy = {1'b0, fifo_count}
                   + (FIFO_CNT_W+1)'(adv_pending)
                   + (FIFO_CNT_W+1)'(trace.valid)
                   + (FIFO_CNT_W+1)'(s3_valid)
                   + (FIFO_CNT_W+1)'(res_valid);
  assign in_tready = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);
  assign in_fire   = in_tvalid && in_tready;

  assign in_rgb.red   = in_tdata[59:44];
  assign in_rgb.green = in_tdata[75:60];
  assign in_rgb.blue  = in_tdata[91:76];

  dab_backtrace u_backtrace (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_mode     (in_tuser),
    .in_cx       (in_tdata[5:0]),
    .in_cy       (in_tdata[11:6]),
    .in_vel_x    ($signed(in_tdata[27:12])),
    .in_vel_y    ($signed(in_tdata[43:28])),
    .in_rgb      (in_rgb),
    .time_step   (time_step_r),
    .mem_req     (mem_req),
    .trace       (trace),
    .adv_pending (adv_pending)
  );

  dab_grid_mem u_grid_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  dab_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .trace     (trace),
    .rd_data   (rd_data),
    .s3_valid  (s3_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  dab_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rd_data   (out_res),
    .count     (fifo_count)
  );

  assign out_tdata = {4'd0, out_res.rgb.blue, out_res.rgb.green, out_res.rgb.red,
                      out_res.y, out_res.x};

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
    else $error("more results in flight than the queue can hold");

  a_result_from_advect: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(in_fire && (in_tuser == MODE_ADVECT), 4))
    else $error("result without an advect transfer four cycles earlier");

  a_load_no_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |=> !trace.valid)
    else $error("load write stage produced a traced advect");

endmodule
